>>> rtl/tps_pkg.sv
`default_nettype none

package tps_pkg;

   // Item modes of the request channel.
   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   // Playback segment codes, also reported on the response channel.
   localparam logic [1:0] SEG_IDLE  = 2'd0;
   localparam logic [1:0] SEG_PRE   = 2'd1;
   localparam logic [1:0] SEG_TONE  = 2'd2;
   localparam logic [1:0] SEG_PAUSE = 2'd3;

   // Register indexes of the CSR port.
   localparam logic [1:0] CSR_PRE_ROLL = 2'd0;
   localparam logic [1:0] CSR_COUNT    = 2'd1;
   localparam logic [1:0] CSR_SPECIAL  = 2'd2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Reset values of the registers.
   localparam logic [15:0] PRE_ROLL_RST = 16'd1000;
   localparam logic [4:0]  COUNT_RST    = 5'd1;
   localparam logic [3:0]  SPECIAL_RST  = 4'd0;

   localparam int LEN_W   = 16;
   localparam int SPEED_W = 12;
   localparam int SCALED_W = 20;

   // One table entry: frequency, tone length, pause length.
   localparam int ENTRY_W = 48;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  step_slot;
      logic [15:0] step_freq;
      logic [15:0] step_tone_ms;
      logic [15:0] step_pause_ms;
      logic [11:0] speed;
      logic        with_pre_roll;
      logic [15:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      logic        tone_started;
      logic        target_started;
      logic        target_ended;
      logic        loop_completed;
      logic        buzzer_on;
      logic [15:0] buzzer_freq;
      logic [19:0] buzzer_length;
      logic [3:0]  current_step;
      logic [1:0]  current_segment;
   } rsp_type;

   // Request into the shared length scaler.
   typedef struct packed {
      logic               start;
      logic [LEN_W-1:0]   len;
      logic [SPEED_W-1:0] speed;
   } scale_req_type;

endpackage

`default_nettype wire

>>> rtl/tone_pattern_sequencer_unit.sv
`default_nettype none

// Channel   Direction  Payload    Handshake
// req_      in         req_type   req_valid / req_stall
// rsp_      out        rsp_type   rsp_valid / rsp_stall
// csr_      in         16 bits    csr_wr_en, csr_index
//
// A load, an unused mode, a zero tick or a tick while idle goes straight to the finish state.
// A start with the pre-roll does too; without it, the start first fetches and scales the first tone.
// A nonzero tick while playing steps through the segments it ends, up to 2*MAX_STEPS+1
// of them, and after a fetch skips the step when its time ran out right at the segment change;
// completing the pattern needs no fetch, since the last pause leads to no new segment.
// Each segment change into a tone or a pause needs one table read and one scaler pass.
// Reset is synchronous; control state clears, the step table keeps its contents.
// The result sits in an output register, so the next request transfer is taken
// while rsp_stall holds an earlier result; that item then waits in its last cycle.

module tone_pattern_sequencer_unit
   import tps_pkg::*;
#(
   parameter int MAX_STEPS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int CNT_W = 9;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_STEPS);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_STEP   = 6'b000010,
      ST_FETCH  = 6'b000100,
      ST_MUL    = 6'b001000,
      ST_APPLY  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   typedef struct packed {
      logic tone;
      logic tstart;
      logic tend;
      logic loop_done;
   } event_type;

   state_type            state_ff, state_in;
   event_type            ev_ff, ev_in;
   logic [1:0]           segment_ff, segment_in;
   logic [IDX_W-1:0]     ptr_ff, ptr_in;
   logic [SCALED_W-1:0]  left_ff, left_in;
   logic [LEN_W-1:0]     dt_ff, dt_in;
   logic [SPEED_W-1:0]   speed_ff, speed_in;
   logic                 sounding_ff, sounding_in;
   logic [15:0]          last_freq_ff, last_freq_in;
   logic [SCALED_W-1:0]  last_len_ff, last_len_in;
   logic [15:0]          pre_roll_ff;
   logic [4:0]           count_ff;
   logic [3:0]           special_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 req_accept;
   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic [ENTRY_W-1:0]   ram_rd_data;
   logic                 ram_rd_en;
   logic [CNT_W-1:0]     slot_ext;
   logic [CNT_W-1:0]     ptr_ext;
   logic [CNT_W-1:0]     eff_count;
   logic                 at_special;
   logic                 more_steps;
   logic [SCALED_W-1:0]  used;
   logic [SCALED_W-1:0]  left_sub;
   scale_req_type        scale_req;
   logic [SCALED_W-1:0]  scaled;

   // Request side is open only between items.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Index helpers, widened so that any table depth compares cleanly.
   assign slot_ext   = CNT_W'(req_data.step_slot);
   assign ptr_ext    = CNT_W'(ptr_ff);
   assign eff_count  = (CNT_W'(count_ff) > MAX_CNT) ? MAX_CNT : CNT_W'(count_ff);
   assign at_special = (ptr_ext == CNT_W'(special_ff));
   assign more_steps = ((ptr_ext + CNT_W'(1)) < eff_count);

   // Step table: load items write it, the sequencer reads the current step.
   assign ram_wr_en   = req_accept && (req_data.mode == MODE_LOAD) && (slot_ext < MAX_CNT);
   assign ram_wr_addr = slot_ext[IDX_W-1:0];
   assign ram_rd_en   = (state_ff == ST_FETCH);

   tps_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_STEPS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data ({req_data.step_freq, req_data.step_tone_ms, req_data.step_pause_ms}),
      .rd_en   (ram_rd_en),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd_data)
   );

   // The shared scaler turns the fetched tone or pause length into ms.
   always_comb begin
      scale_req.start = (state_ff == ST_MUL);
      scale_req.speed = speed_ff;
      scale_req.len   = (segment_ff == SEG_TONE) ? ram_rd_data[31:16] : ram_rd_data[15:0];
   end

   tps_scaler u_scaler (
      .clock     (clock),
      .scale_req (scale_req),
      .scaled    (scaled)
   );

   // Time consumed from the current segment in one step.
   assign used     = (SCALED_W'(dt_ff) < left_ff) ? SCALED_W'(dt_ff) : left_ff;
   assign left_sub = left_ff - used;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      ev_in        = ev_ff;
      segment_in   = segment_ff;
      ptr_in       = ptr_ff;
      left_in      = left_ff;
      dt_in        = dt_ff;
      speed_in     = speed_ff;
      sounding_in  = sounding_ff;
      last_freq_in = last_freq_ff;
      last_len_in  = last_len_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               ev_in    = '0;
               state_in = ST_FINISH;
               case (req_data.mode)
                  MODE_START: begin
                     speed_in = req_data.speed;
                     ptr_in   = '0;
                     dt_in    = '0;
                     if (req_data.with_pre_roll) begin
                        segment_in  = SEG_PRE;
                        left_in     = SCALED_W'(pre_roll_ff);
                        sounding_in = 1'b0;
                     end else begin
                        segment_in = SEG_TONE;
                        state_in   = ST_FETCH;
                     end
                  end
                  MODE_TICK: begin
                     dt_in = req_data.elapsed_ms;
                     if ((segment_ff != SEG_IDLE) && (req_data.elapsed_ms != '0)) begin
                        state_in = ST_STEP;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_STEP: begin
            left_in  = left_sub;
            dt_in    = dt_ff - used[LEN_W-1:0];
            state_in = ST_FINISH;
            if (left_sub == '0) begin
               case (segment_ff)
                  SEG_PRE: begin
                     segment_in = SEG_TONE;
                     state_in   = ST_FETCH;
                  end
                  SEG_TONE: begin
                     sounding_in = 1'b0;
                     ev_in.tend  = ev_ff.tend || at_special;
                     segment_in  = SEG_PAUSE;
                     state_in    = ST_FETCH;
                  end
                  SEG_PAUSE: begin
                     if (more_steps) begin
                        ptr_in     = ptr_ff + IDX_W'(1);
                        segment_in = SEG_TONE;
                        state_in   = ST_FETCH;
                     end else begin
                        ev_in.loop_done = 1'b1;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            left_in = scaled;
            if (segment_ff == SEG_TONE) begin
               last_freq_in = ram_rd_data[47:32];
               last_len_in  = scaled;
               sounding_in  = 1'b1;
               ev_in.tone   = 1'b1;
               ev_in.tstart = ev_ff.tstart || at_special;
            end
            state_in = (dt_ff != '0) ? ST_STEP : ST_FINISH;
         end
         ST_FINISH: begin
            // Load the output register once it is free or being taken.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.tone_started    = ev_ff.tone;
               rsp_data_in.target_started  = ev_ff.tstart;
               rsp_data_in.target_ended    = ev_ff.tend;
               rsp_data_in.loop_completed  = ev_ff.loop_done;
               rsp_data_in.buzzer_on       = sounding_ff;
               rsp_data_in.buzzer_freq     = last_freq_ff;
               rsp_data_in.buzzer_length   = last_len_ff;
               rsp_data_in.current_step    = ptr_ext[3:0];
               rsp_data_in.current_segment = segment_ff;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         segment_ff   <= SEG_IDLE;
         ptr_ff       <= '0;
         left_ff      <= '0;
         speed_ff     <= '0;
         sounding_ff  <= 1'b0;
         last_freq_ff <= '0;
         last_len_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         segment_ff   <= segment_in;
         ptr_ff       <= ptr_in;
         left_ff      <= left_in;
         speed_ff     <= speed_in;
         sounding_ff  <= sounding_in;
         last_freq_ff <= last_freq_in;
         last_len_ff  <= last_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and the result payload.
   always_ff @(posedge clock) begin
      ev_ff       <= ev_in;
      dt_ff       <= dt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pre_roll_ff <= PRE_ROLL_RST;
         count_ff    <= COUNT_RST;
         special_ff  <= SPECIAL_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PRE_ROLL: pre_roll_ff <= csr_wdata;
            CSR_COUNT:    count_ff    <= csr_wdata[4:0];
            CSR_SPECIAL:  special_ff  <= csr_wdata[3:0];
            default: begin
               pre_roll_ff <= pre_roll_ff;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A request transfer only happens between items.
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (state_ff == ST_IDLE))
      else $error("request taken while an item is in progress");

   // The scaler result is used in the cycle after it was started.
   a_apply_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |-> $past(state_ff == ST_MUL))
      else $error("apply without a scaler pass");

   // Table reads only happen for a tone or a pause.
   a_fetch_seg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> (segment_ff == SEG_TONE || segment_ff == SEG_PAUSE))
      else $error("table fetch outside tone or pause");

   // The buzzer never sounds while playback is idle.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (segment_ff == SEG_IDLE) |-> !sounding_ff)
      else $error("buzzer on while idle");

   // A new result is only loaded at the end of an item.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");

endmodule

`default_nettype wire

>>> rtl/tps_ram.sv
`default_nettype none

module tps_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [ADDR_W-1:0]      wr_addr,
   input  wire logic [WIDTH-1:0]       wr_data,
   input  wire logic                   rd_en,
   input  wire logic [ADDR_W-1:0]      rd_addr,
   output logic      [WIDTH-1:0]       rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/tps_scaler.sv
`default_nettype none

module tps_scaler
   import tps_pkg::*;
(
   input  wire logic                clock,
   input  wire scale_req_type       scale_req,
   output logic [SCALED_W-1:0]      scaled
);
   logic [LEN_W+SPEED_W-1:0] product;
   logic [SCALED_W-1:0]      scaled_ff;

   // Q4.8 scaling: the product drops its eight fraction bits.
   assign product = (LEN_W+SPEED_W)'(scale_req.len) * (LEN_W+SPEED_W)'(scale_req.speed);

   always_ff @(posedge clock) begin
      if (scale_req.start) begin
         scaled_ff <= product[LEN_W+SPEED_W-1:8];
      end
   end

   assign scaled = scaled_ff;

endmodule

`default_nettype wire
